>>> rtl/cpf_pkg.sv
// ----------------------------------------------------------------------------
// cpf_pkg
// Types, register indexes and check helpers shared by the packet framer.
// ----------------------------------------------------------------------------
package cpf_pkg;

  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  localparam logic MODE_SUM = 1'b0;
  localparam logic MODE_CRC = 1'b1;

  localparam int unsigned REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_MODE  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_START = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_STOP  = 2'd2;

  localparam logic [15:0] CRC_POLY = 16'h8408;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] SUM_INIT = 16'h0000;

  localparam logic [7:0] RST_START_MARKER = 8'd1;
  localparam logic [7:0] RST_STOP_MARKER  = 8'd23;

  localparam int unsigned STEP_W = 3;
  localparam int unsigned MAX_STEP = 6;

  typedef enum logic [1:0] {
    CMD_BEGIN,
    CMD_DATA,
    CMD_ERROR
  } cmd_kind_e;

  typedef struct packed {
    logic        op;
    logic [7:0]  cmd_code;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       error;
  } out_t;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  cmd_code;
    logic [15:0] len;
    logic [7:0]  data;
    logic        fin;
  } cmd_t;

  typedef struct packed {
    logic       checksum_mode;
    logic [7:0] start_marker;
    logic [7:0] stop_marker;
  } cfg_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [15:0] absorb(input logic mode, input logic [15:0] acc,
                                         input logic [7:0] b);
    logic [15:0] r;
    if (mode == MODE_CRC) begin
      r = crc_byte(acc, b);
    end else begin
      r = acc + {8'h00, b};
    end
    return r;
  endfunction

endpackage

>>> rtl/cpf_front.sv
// ----------------------------------------------------------------------------
// cpf_front
// Accepts requests, tracks the open packet and queues classified commands.
// ----------------------------------------------------------------------------
module cpf_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  input  logic           q_full_i,
  input  cpf_pkg::in_t   req_i,
  output logic           cmd_push_o,
  output cpf_pkg::cmd_t  cmd_o
);

  logic        open_q, open_d;
  logic [15:0] remaining_q, remaining_d;
  logic [15:0] rem_dec;

  assign cmd_push_o = push && !q_full_i;
  assign rem_dec    = remaining_q - 16'd1;

  always_comb begin
    open_d       = open_q;
    remaining_d  = remaining_q;
    cmd_o.cmd_code = req_i.cmd_code;
    cmd_o.len      = req_i.payload_length;
    cmd_o.data     = req_i.data_byte;
    cmd_o.fin      = 1'b0;
    cmd_o.kind     = cpf_pkg::CMD_ERROR;
    if (req_i.op == cpf_pkg::OP_BEGIN) begin
      cmd_o.kind = cpf_pkg::CMD_BEGIN;
      if (req_i.payload_length == 16'd0) begin
        cmd_o.fin   = 1'b1;
        open_d      = 1'b0;
        remaining_d = 16'd0;
      end else begin
        open_d      = 1'b1;
        remaining_d = req_i.payload_length;
      end
    end else if (open_q) begin
      cmd_o.kind  = cpf_pkg::CMD_DATA;
      remaining_d = rem_dec;
      if (rem_dec == 16'd0) begin
        cmd_o.fin = 1'b1;
        open_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= 1'b0;
      remaining_q <= 16'd0;
    end else if (cmd_push_o) begin
      open_q      <= open_d;
      remaining_q <= remaining_d;
    end
  end

endmodule

>>> rtl/cpf_fifo.sv
// ----------------------------------------------------------------------------
// cpf_fifo
// Short command queue between the front and back halves.
// ----------------------------------------------------------------------------
module cpf_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  cpf_pkg::cmd_t  wr_data_i,
  input  logic           rd_i,
  output cpf_pkg::cmd_t  rd_data_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cpf_pkg::cmd_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_wr, do_rd;

  assign full_o    = (count_q == CNT_W'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue count above depth");

endmodule

>>> rtl/cpf_back.sv
// ----------------------------------------------------------------------------
// cpf_back
// Expands queued commands into framed bytes and keeps the running check.
// ----------------------------------------------------------------------------
module cpf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cpf_pkg::cfg_t  cfg_i,
  input  cpf_pkg::cmd_t  head_i,
  input  logic           head_empty_i,
  output logic           head_pop_o,
  input  logic           pop,
  output logic           empty,
  output cpf_pkg::out_t  rsp_o
);

  logic [cpf_pkg::STEP_W-1:0] step_q;
  logic [15:0]                acc_q, acc_base, acc_d;
  logic                       out_valid_q;
  cpf_pkg::out_t              out_q, out_d;
  logic                       fire, do_absorb;
  logic [15:0]                crc_out, sum_out;
  logic [7:0]                 chk_first, chk_second;

  assign crc_out = ~acc_q;
  assign sum_out = 16'd0 - acc_q;

  always_comb begin
    if (cfg_i.checksum_mode == cpf_pkg::MODE_CRC) begin
      chk_first  = crc_out[15:8];
      chk_second = crc_out[7:0];
    end else begin
      chk_first  = sum_out[7:0];
      chk_second = sum_out[15:8];
    end
  end

  always_comb begin
    out_d     = '0;
    do_absorb = 1'b0;
    acc_base  = acc_q;
    case (head_i.kind)
      cpf_pkg::CMD_BEGIN: begin
        case (step_q)
          3'd0: begin
            out_d.out_byte = cfg_i.start_marker;
            do_absorb      = 1'b1;
            acc_base       = (cfg_i.checksum_mode == cpf_pkg::MODE_CRC) ?
                             cpf_pkg::CRC_INIT : cpf_pkg::SUM_INIT;
          end
          3'd1: begin
            out_d.out_byte = head_i.cmd_code;
            do_absorb      = 1'b1;
          end
          3'd2: begin
            out_d.out_byte = head_i.len[7:0];
            do_absorb      = 1'b1;
          end
          3'd3: begin
            out_d.out_byte = head_i.len[15:8];
            out_d.last     = !head_i.fin;
            do_absorb      = 1'b1;
          end
          3'd4: out_d.out_byte = chk_first;
          3'd5: out_d.out_byte = chk_second;
          default: begin
            out_d.out_byte = cfg_i.stop_marker;
            out_d.last     = 1'b1;
          end
        endcase
      end
      cpf_pkg::CMD_DATA: begin
        case (step_q)
          3'd0: begin
            out_d.out_byte = head_i.data;
            out_d.last     = !head_i.fin;
            do_absorb      = 1'b1;
          end
          3'd1: out_d.out_byte = chk_first;
          3'd2: out_d.out_byte = chk_second;
          default: begin
            out_d.out_byte = cfg_i.stop_marker;
            out_d.last     = 1'b1;
          end
        endcase
      end
      default: begin
        out_d.last  = 1'b1;
        out_d.error = 1'b1;
      end
    endcase
  end

  assign acc_d      = cpf_pkg::absorb(cfg_i.checksum_mode, acc_base, out_d.out_byte);
  assign fire       = !head_empty_i && (!out_valid_q || pop);
  assign head_pop_o = fire && out_d.last;
  assign empty      = !out_valid_q;
  assign rsp_o      = out_q;

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        out_valid_q <= 1'b1;
        step_q      <= out_d.last ? '0 : step_q + cpf_pkg::STEP_W'(1);
        if (do_absorb) begin
          acc_q <= acc_d;
        end
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= cpf_pkg::STEP_W'(cpf_pkg::MAX_STEP))
    else $error("sequencer step out of range");

  a_mid_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != '0) |-> !head_empty_i)
    else $error("command left the queue mid-sequence");

endmodule

>>> rtl/checksummed_command_packet_framer.sv
// ----------------------------------------------------------------------------
// checksummed_command_packet_framer
// Frames command packets with start marker, header, payload, check, stop.
// ----------------------------------------------------------------------------
// A taken request passes the command queue, then the output register. The back
// sequencer gives one result byte per cycle unless the receiver stalls; a payload request
// gives its data byte (the last adds check, stop), a begin request marker, code, length (empty adds check, stop).
// Input stalls only when the FIFO_DEPTH-entry command queue fills.
// Reset: asynchronous, clears queue, sequencer, packet state and restores the
// register defaults (sum mode, start 1, stop 23).
module checksummed_command_packet_framer #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  cpf_pkg::in_t                      req_i,
  output logic                              empty,
  input  logic                              pop,
  output cpf_pkg::out_t                     rsp_o,
  input  logic                              cfg_we_i,
  input  logic [cpf_pkg::REG_IDX_W-1:0]     cfg_idx_i,
  input  logic [7:0]                        cfg_data_i
);

  cpf_pkg::cfg_t cfg_q;
  cpf_pkg::cmd_t cmd_in, cmd_head;
  logic          cmd_push, head_pop, q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.checksum_mode <= cpf_pkg::MODE_SUM;
      cfg_q.start_marker  <= cpf_pkg::RST_START_MARKER;
      cfg_q.stop_marker   <= cpf_pkg::RST_STOP_MARKER;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cpf_pkg::REG_MODE:  cfg_q.checksum_mode <= cfg_data_i[0];
        cpf_pkg::REG_START: cfg_q.start_marker  <= cfg_data_i;
        cpf_pkg::REG_STOP:  cfg_q.stop_marker   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cpf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .q_full_i   (full),
    .req_i      (req_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  cpf_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (cmd_push),
    .wr_data_i (cmd_in),
    .rd_i      (head_pop),
    .rd_data_o (cmd_head),
    .full_o    (full),
    .empty_o   (q_empty)
  );

  cpf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_i       (cmd_head),
    .head_empty_i (q_empty),
    .head_pop_o   (head_pop),
    .pop          (pop),
    .empty        (empty),
    .rsp_o        (rsp_o)
  );

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && rsp_o.error) |-> (rsp_o.last && rsp_o.out_byte == 8'd0))
    else $error("error result not a lone zero byte");

endmodule

>>> verif/tb_checksummed_command_packet_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_checksummed_command_packet_framer
// Self-checking bench for the command packet framer. A short table of
// directed requests covers the length extremes, stray payload, abandoned
// packets, marker extremes and mode changes inside a packet. Random packets
// follow under several register settings. The sender runs in bursts and the
// receiver stalls on a rotating pattern. Every framed byte is checked against
// a local model of the framer or against bytes typed into the table.
// ----------------------------------------------------------------------------
module tb_checksummed_command_packet_framer;

  localparam int unsigned ITEM_TARGET   = 420;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES   = 16;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam logic [15:0] CRC16_POLY    = 16'h8408;
  localparam logic [15:0] CRC16_SEED    = 16'hFFFF;

  typedef struct {
    logic            is_cfg;
    logic            mode;
    logic [7:0]      start_m;
    logic [7:0]      stop_m;
    cpf_pkg::in_t    req;
    int              n_typed;
    logic [0:6][7:0] typed;
    logic            typed_err;
  } step_t;

  logic                          clk_i      = 1'b0;
  logic                          rst_ni     = 1'b0;
  logic                          push       = 1'b0;
  logic                          full;
  cpf_pkg::in_t                  req_d      = '0;
  logic                          empty;
  logic                          pop        = 1'b0;
  cpf_pkg::out_t                 rsp;
  logic                          cfg_we_i   = 1'b0;
  logic [cpf_pkg::REG_IDX_W-1:0] cfg_idx_i  = cpf_pkg::REG_MODE;
  logic [7:0]                    cfg_data_i = '0;

  logic                 full_seen  = 1'b1;
  logic                 empty_seen = 1'b1;
  cpf_pkg::out_t        rsp_seen   = '0;

  logic [15:0]          stall_pattern = 16'hB6D9;
  logic [3:0]           pop_phase     = '0;
  int unsigned          idle_cycles   = 0;
  int unsigned          n_fail        = 0;
  int unsigned          n_sent        = 0;
  int unsigned          burst_left    = 0;
  logic                 bursty        = 1'b1;

  // framer model state
  logic                 cur_mode  = cpf_pkg::MODE_SUM;
  logic [7:0]           cur_start = 8'd1;
  logic [7:0]           cur_stop  = 8'd23;
  logic [15:0]          bytes_left = '0;
  logic [15:0]          check_acc  = '0;
  logic                 in_packet  = 1'b0;

  cpf_pkg::out_t        predicted[$];
  cpf_pkg::out_t        framed_bytes_due[$];

  checksummed_command_packet_framer DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .req_i      (req_d),
    .empty      (empty),
    .pop        (pop),
    .rsp_o      (rsp),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    full_seen  <= full;
    empty_seen <= empty;
    rsp_seen   <= rsp;
  end

  function automatic void fold_byte(input logic [7:0] b);
    logic [15:0] c;
    if (cur_mode == cpf_pkg::MODE_CRC) begin
      c = check_acc ^ {8'h00, b};
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
      check_acc = c;
    end else begin
      check_acc = check_acc + {8'h00, b};
    end
  endfunction

  function automatic void emit_byte(input logic [7:0] b);
    fold_byte(b);
    predicted.push_back(cpf_pkg::out_t'{b, 1'b0, 1'b0});
  endfunction

  function automatic void close_frame();
    logic [15:0] v;
    if (cur_mode == cpf_pkg::MODE_CRC) begin
      v = ~check_acc;
      predicted.push_back(cpf_pkg::out_t'{v[15:8], 1'b0, 1'b0});
      predicted.push_back(cpf_pkg::out_t'{v[7:0], 1'b0, 1'b0});
    end else begin
      v = 16'h0000 - check_acc;
      predicted.push_back(cpf_pkg::out_t'{v[7:0], 1'b0, 1'b0});
      predicted.push_back(cpf_pkg::out_t'{v[15:8], 1'b0, 1'b0});
    end
    predicted.push_back(cpf_pkg::out_t'{cur_stop, 1'b1, 1'b0});
    in_packet  = 1'b0;
    bytes_left = '0;
  endfunction

  function automatic void frame_request(input cpf_pkg::in_t r);
    predicted.delete();
    if (r.op == cpf_pkg::OP_BEGIN) begin
      check_acc = (cur_mode == cpf_pkg::MODE_CRC) ? CRC16_SEED : 16'h0000;
      emit_byte(cur_start);
      emit_byte(r.cmd_code);
      emit_byte(r.payload_length[7:0]);
      emit_byte(r.payload_length[15:8]);
      if (r.payload_length == 16'd0) begin
        close_frame();
      end else begin
        bytes_left = r.payload_length;
        in_packet  = 1'b1;
        predicted[predicted.size()-1].last = 1'b1;
      end
    end else if (!in_packet) begin
      predicted.push_back(cpf_pkg::out_t'{8'h00, 1'b1, 1'b1});
    end else begin
      emit_byte(r.data_byte);
      bytes_left = bytes_left - 16'd1;
      if (bytes_left == 16'd0) begin
        close_frame();
      end else begin
        predicted[predicted.size()-1].last = 1'b1;
      end
    end
  endfunction

  function automatic cpf_pkg::in_t rand_request(input logic op);
    cpf_pkg::in_t r;
    r.op             = op;
    r.cmd_code       = 8'($urandom_range(0, 255));
    r.payload_length = 16'($urandom_range(0, 65535));
    r.data_byte      = 8'($urandom_range(0, 255));
    return r;
  endfunction

  function automatic step_t req_row(input logic op, input logic [7:0] cmd,
                                    input logic [15:0] len, input logic [7:0] data,
                                    input int n_typed = 0,
                                    input logic [0:6][7:0] typed = '0,
                                    input logic typed_err = 1'b0);
    step_t s;
    s.is_cfg    = 1'b0;
    s.mode      = cpf_pkg::MODE_SUM;
    s.start_m   = '0;
    s.stop_m    = '0;
    s.req       = cpf_pkg::in_t'{op, cmd, len, data};
    s.n_typed   = n_typed;
    s.typed     = typed;
    s.typed_err = typed_err;
    return s;
  endfunction

  function automatic step_t cfg_row(input logic mode, input logic [7:0] start_m,
                                    input logic [7:0] stop_m);
    step_t s;
    s           = req_row(cpf_pkg::OP_BEGIN, '0, '0, '0);
    s.is_cfg    = 1'b1;
    s.mode      = mode;
    s.start_m   = start_m;
    s.stop_m    = stop_m;
    return s;
  endfunction

  task automatic offer(input cpf_pkg::in_t r, input int n_typed = 0,
                       input logic [0:6][7:0] typed = '0, input logic typed_err = 1'b0);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = bursty ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    push  <= 1'b1;
    req_d <= r;
    @(posedge clk_i);
    while (full_seen) @(posedge clk_i);
    n_sent++;
    frame_request(r);
    if (n_typed == 0) begin
      foreach (predicted[k]) framed_bytes_due.push_back(predicted[k]);
    end else begin
      for (int k = 0; k < n_typed; k++) begin
        framed_bytes_due.push_back(cpf_pkg::out_t'{typed[k], k == n_typed - 1, typed_err});
      end
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    while (framed_bytes_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic retune(input logic mode, input logic [7:0] start_m,
                        input logic [7:0] stop_m);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= cpf_pkg::REG_MODE;
    cfg_data_i <= {7'b0, mode};
    @(posedge clk_i);
    cfg_idx_i  <= cpf_pkg::REG_START;
    cfg_data_i <= start_m;
    @(posedge clk_i);
    cfg_idx_i  <= cpf_pkg::REG_STOP;
    cfg_data_i <= stop_m;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_mode   = mode;
    cur_start  = start_m;
    cur_stop   = stop_m;
    burst_left = 0;
  endtask

  always @(posedge clk_i) begin : result_check
    cpf_pkg::out_t want;
    pop_phase <= pop_phase + 4'd1;
    pop       <= stall_pattern[pop_phase];
    if ((push && !full_seen) || (pop && !empty_seen)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (pop && !empty_seen) begin
      if (framed_bytes_due.size() == 0) begin
        n_fail++;
        if (n_fail <= MAX_REPORTS) begin
          $display("%0t: unexpected byte %02h last %0b error %0b", $realtime,
                   rsp_seen.out_byte, rsp_seen.last, rsp_seen.error);
        end
      end else begin
        want = framed_bytes_due.pop_front();
        if (rsp_seen.out_byte !== want.out_byte || rsp_seen.last !== want.last ||
            rsp_seen.error !== want.error) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS) begin
            $display("%0t: expected byte %02h last %0b error %0b, got %02h %0b %0b",
                     $realtime, want.out_byte, want.last, want.error,
                     rsp_seen.out_byte, rsp_seen.last, rsp_seen.error);
          end
        end
      end
    end
  end

  initial begin : watchdog
    do @(posedge clk_i); while (idle_cycles < STALL_LIMIT);
    $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    step_t        steps[$];
    cpf_pkg::in_t r;
    int unsigned  pick;
    int unsigned  n_body;
    int unsigned  phase_end;
    logic [7:0]   s_m;
    logic [7:0]   p_m;

    steps.push_back(req_row(cpf_pkg::OP_DATA,  8'h00, 16'h0000, 8'hA5, 1, '0, 1'b1));
    steps.push_back(req_row(cpf_pkg::OP_BEGIN, 8'h00, 16'h0000, 8'h00, 7,
                            {8'h01, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'd23}));
    steps.push_back(req_row(cpf_pkg::OP_BEGIN, 8'hFF, 16'hFFFF, 8'hFF, 4,
                            {8'h01, 8'hFF, 8'hFF, 8'hFF, 24'h0}));
    steps.push_back(req_row(cpf_pkg::OP_DATA,  8'h00, 16'h0000, 8'h00));
    steps.push_back(req_row(cpf_pkg::OP_DATA,  8'hFF, 16'hFFFF, 8'hFF));
    steps.push_back(req_row(cpf_pkg::OP_BEGIN, 8'h3C, 16'h0002, 8'h00));
    steps.push_back(req_row(cpf_pkg::OP_DATA,  8'h00, 16'h0000, 8'h12));
    steps.push_back(req_row(cpf_pkg::OP_DATA,  8'h00, 16'h0000, 8'h34));
    steps.push_back(req_row(cpf_pkg::OP_DATA,  8'hFF, 16'hFFFF, 8'hFF, 1, '0, 1'b1));
    steps.push_back(cfg_row(cpf_pkg::MODE_CRC, 8'hFF, 8'h00));
    steps.push_back(req_row(cpf_pkg::OP_BEGIN, 8'h80, 16'h0000, 8'h00));
    steps.push_back(req_row(cpf_pkg::OP_BEGIN, 8'h01, 16'h0003, 8'h00));
    steps.push_back(req_row(cpf_pkg::OP_DATA,  8'h00, 16'h0000, 8'h55));
    steps.push_back(cfg_row(cpf_pkg::MODE_SUM, 8'hFF, 8'h00));
    steps.push_back(req_row(cpf_pkg::OP_DATA,  8'h00, 16'h0000, 8'hAA));
    steps.push_back(cfg_row(cpf_pkg::MODE_CRC, 8'hFF, 8'h00));
    steps.push_back(req_row(cpf_pkg::OP_DATA,  8'h00, 16'h0000, 8'h0F));
    steps.push_back(cfg_row(cpf_pkg::MODE_SUM, 8'h00, 8'hFF));
    steps.push_back(req_row(cpf_pkg::OP_BEGIN, 8'h7E, 16'h0001, 8'h00));
    steps.push_back(cfg_row(cpf_pkg::MODE_CRC, 8'h00, 8'hFF));
    steps.push_back(req_row(cpf_pkg::OP_DATA,  8'h00, 16'h0000, 8'h80));
    steps.push_back(req_row(cpf_pkg::OP_BEGIN, 8'hC3, 16'h0100, 8'h00));
    steps.push_back(req_row(cpf_pkg::OP_BEGIN, 8'h00, 16'h8001, 8'h00));
    steps.push_back(req_row(cpf_pkg::OP_BEGIN, 8'h5A, 16'h0001, 8'h00));
    steps.push_back(req_row(cpf_pkg::OP_DATA,  8'h00, 16'h0000, 8'h81));
    steps.push_back(cfg_row(cpf_pkg::MODE_SUM, 8'd1, 8'd23));
    steps.push_back(req_row(cpf_pkg::OP_BEGIN, 8'h0F, 16'h0000, 8'h00, 7,
                            {8'h01, 8'h0F, 8'h00, 8'h00, 8'hF0, 8'hFF, 8'd23}));
    steps.push_back(req_row(cpf_pkg::OP_DATA,  8'h00, 16'h0000, 8'h00, 1, '0, 1'b1));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (steps[i]) begin
      if (steps[i].is_cfg) begin
        retune(steps[i].mode, steps[i].start_m, steps[i].stop_m);
      end else begin
        offer(steps[i].req, steps[i].n_typed, steps[i].typed, steps[i].typed_err);
      end
    end

    while (n_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 3);
      if (pick == 0) begin
        s_m = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
        p_m = ~s_m;
      end else begin
        s_m = 8'($urandom_range(0, 255));
        p_m = 8'($urandom_range(0, 255));
      end
      retune(1'($urandom_range(0, 1)), s_m, p_m);
      bursty = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) == 0) begin
        stall_pattern <= '1;
      end else begin
        stall_pattern <= 16'($urandom) | (16'h0001 << $urandom_range(0, 15));
      end
      phase_end = n_sent + $urandom_range(40, 80);
      while (n_sent < phase_end && n_sent < ITEM_TARGET) begin
        if ($urandom_range(0, 99) < 8) begin
          offer(rand_request(cpf_pkg::OP_DATA));
        end else begin
          r = rand_request(cpf_pkg::OP_BEGIN);
          pick = $urandom_range(0, 99);
          if (pick < 70) begin
            r.payload_length = 16'($urandom_range(0, 6));
          end else if (pick < 95) begin
            r.payload_length = 16'($urandom_range(7, 24));
          end
          n_body = (r.payload_length > 16'd24) ? 24 : r.payload_length;
          if (r.payload_length > 16'd24 || $urandom_range(0, 9) == 0) begin
            n_body = $urandom_range(0, n_body);
          end
          offer(r);
          repeat (n_body) offer(rand_request(cpf_pkg::OP_DATA));
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (framed_bytes_due.size() != 0) n_fail++;
    if (n_fail == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> checksummed_command_packet_framer.f
rtl/cpf_pkg.sv
rtl/cpf_front.sv
rtl/cpf_fifo.sv
rtl/cpf_back.sv
rtl/checksummed_command_packet_framer.sv
verif/tb_checksummed_command_packet_framer.sv
